>>> src/sfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the frame receiver
// Phase codes, frame layout constants and the packed result record.
// ----------------------------------------------------------------------------
package sfr_pkg;

   // Receive phase codes; the unused code behaves as hunting
   localparam logic [1:0] PH_HUNT   = 2'd0;
   localparam logic [1:0] PH_LENGTH = 2'd1;
   localparam logic [1:0] PH_BODY   = 2'd2;

   localparam logic [7:0] START_MARKER = 8'hFF;
   localparam logic [8:0] FIELD_FIRST  = 9'd6;
   localparam logic [8:0] FIELD_LAST   = 9'd9;
   localparam logic [8:0] BODY_START   = 9'd2;
   localparam logic [8:0] LENGTH_POS   = 9'd1;

   localparam int RESULT_BITS = 42;
   localparam int RSP_BYTES   = (RESULT_BITS + 7) / 8;
   localparam int RSP_WIDTH   = RSP_BYTES * 8;

   // One frame report, first field in the highest bits
   typedef struct packed {
      logic       indicator_on;
      logic [7:0] frame_number;
      logic [7:0] frame_size;
      logic [7:0] dead_time;
      logic [7:0] slot_size;
      logic [7:0] frame_length;
      logic       frame_status;
   } result_type;

endpackage
`default_nettype wire

>>> src/sync_frame_receiver_core.sv
// Output: a report is registered in the output register (the skid register
// when that stalls) on the transfer of the checksum or zero length byte.
// Throughput: one byte per cycle while req_tready is high; the parser
// state takes each accepted byte; a two-entry output stage absorbs a stall.
// Reset: synchronous, active high; returns to hunting and clears the sum,
// the held length and the held field bytes; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sync_frame_receiver_core: length-prefixed frame receiver
// Checks marker/length/body frames with an additive checksum and reports
// status, length, field bytes and indicator bit for each completed frame.
// ----------------------------------------------------------------------------
module sync_frame_receiver_core (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_tvalid,
   output logic                          req_tready,
   input  wire  [7:0]                    req_tdata,  // [7:0] rx_byte
   output logic                          rsp_tvalid,
   input  wire                           rsp_tready,
   // [0] frame_status, [8:1] frame_length, [16:9] slot_size,
   // [24:17] dead_time, [32:25] frame_size, [40:33] frame_number,
   // [41] indicator_on, upper bits zero
   output logic [sfr_pkg::RSP_WIDTH-1:0] rsp_tdata
);
   import sfr_pkg::*;

   logic       req_take;
   logic       new_valid;
   result_type new_result;
   logic       out_drain;

   logic       out_valid_ff,  out_valid_in;
   result_type out_data_ff,   out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff,  skid_data_in;

   assign req_tready = ~skid_valid_ff;
   assign req_take   = req_tvalid && req_tready;
   assign out_drain  = out_valid_ff && rsp_tready;

   sfr_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (req_take),
      .byte_data    (req_tdata),
      .result_valid (new_valid),
      .result       (new_result)
   );

   // Route reports into the output register or the skid stage
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_drain) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (new_valid) begin
            out_valid_in = 1'b1;
            out_data_in  = new_result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (new_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = new_result;
      end
   end

   // Hold control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_WIDTH - RESULT_BITS){1'b0}}, out_data_ff};

endmodule
`default_nettype wire

>>> src/sfr_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_parser: frame state tracker
// Follows marker, length and body bytes, keeps the running sum and the
// field bytes, and raises a frame report on the checksum or zero length byte.
// ----------------------------------------------------------------------------
module sfr_parser (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      byte_valid,
   input  wire  [7:0]               byte_data,
   output logic                     result_valid,
   output sfr_pkg::result_type      result
);
   import sfr_pkg::*;

   logic [1:0] phase_ff,    phase_in;
   logic [8:0] position_ff, position_in;
   logic [7:0] length_ff,   length_in;
   logic [7:0] sum_ff,      sum_in;
   logic [7:0] prev_ff,     prev_in;
   logic [7:0] field_ff [4];
   logic [7:0] field_in [4];

   logic       at_field;
   logic [1:0] field_idx;
   logic [8:0] position_sub;
   logic [8:0] last_pos;
   logic       emit_length;
   logic       emit_body;
   logic       frame_done;
   logic [7:0] report_length;

   assign position_sub = position_ff - FIELD_FIRST;
   assign field_idx    = position_sub[1:0];
   assign at_field     = (position_ff >= FIELD_FIRST) && (position_ff <= FIELD_LAST);
   assign last_pos     = {1'b0, length_ff} + 9'd1;
   assign emit_length  = (phase_ff == PH_LENGTH) && (byte_data == 8'd0);
   assign emit_body    = (phase_ff == PH_BODY) && (position_ff >= last_pos);
   assign frame_done   = emit_length || emit_body;

   // Compute next state for an accepted byte
   always_comb begin
      phase_in    = phase_ff;
      position_in = position_ff;
      length_in   = length_ff;
      sum_in      = sum_ff;
      prev_in     = prev_ff;
      for (int i = 0; i < 4; i++) begin
         field_in[i] = field_ff[i];
      end
      if (byte_valid) begin
         case (phase_ff)
            PH_LENGTH: begin
               length_in = byte_data;
               if (byte_data == 8'd0) begin
                  phase_in    = PH_HUNT;
                  position_in = '0;
               end else begin
                  sum_in      = sum_ff + byte_data;
                  prev_in     = byte_data;
                  position_in = BODY_START;
                  phase_in    = PH_BODY;
               end
            end
            PH_BODY: begin
               if (at_field) begin
                  field_in[field_idx] = byte_data;
               end
               if (emit_body) begin
                  phase_in    = PH_HUNT;
                  position_in = '0;
               end else begin
                  sum_in      = sum_ff + byte_data;
                  prev_in     = byte_data;
                  position_in = position_ff + 9'd1;
               end
            end
            default: begin
               // Hunt: drop everything but the start marker
               if (byte_data == START_MARKER) begin
                  sum_in      = byte_data;
                  prev_in     = byte_data;
                  position_in = LENGTH_POS;
                  phase_in    = PH_LENGTH;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
         endcase
      end
   end

   // Build the report from the updated field bytes and the pre-checksum sum
   assign report_length = (phase_ff == PH_LENGTH) ? byte_data : length_ff;
   assign result_valid  = byte_valid && frame_done;

   always_comb begin
      result.frame_status = ((~sum_ff) != byte_data);
      result.frame_length = report_length;
      result.slot_size    = field_in[0];
      result.dead_time    = field_in[1];
      result.frame_size   = field_in[2];
      result.frame_number = field_in[3];
      result.indicator_on = ~prev_ff[0];
   end

   // Hold frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         position_ff <= '0;
         length_ff   <= '0;
         sum_ff      <= '0;
         prev_ff     <= '0;
         for (int i = 0; i < 4; i++) begin
            field_ff[i] <= '0;
         end
      end else begin
         phase_ff    <= phase_in;
         position_ff <= position_in;
         length_ff   <= length_in;
         sum_ff      <= sum_in;
         prev_ff     <= prev_in;
         for (int i = 0; i < 4; i++) begin
            field_ff[i] <= field_in[i];
         end
      end
   end

endmodule
`default_nettype wire

>>> dv/tb_sync_frame_receiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_frame_receiver_core: self-checking bench for the frame receiver
// Streams directed and random byte sequences (frames, noise, broken frames)
// into the block. A scoreboard tracks the receiver's parse state, queues the
// expected frame reports and compares every report transfer field by field.
// ----------------------------------------------------------------------------
module tb_sync_frame_receiver_core;
   import sfr_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int BYTE_TARGET  = 1550;
   localparam int TAIL_CYCLES  = 8;

   // Track the parse state and hold the frame reports still due
   class frame_scoreboard;
      logic [1:0] phase;
      logic [8:0] position;
      logic [7:0] length_held;
      logic [7:0] running_sum;
      logic [7:0] previous_byte;
      logic [7:0] field_bytes [4];
      result_type reports_due [$];
      int         errors;
      int         reports_seen;

      function new();
         phase         = PH_HUNT;
         position      = '0;
         length_held   = '0;
         running_sum   = '0;
         previous_byte = '0;
         foreach (field_bytes[i]) field_bytes[i] = '0;
         errors        = 0;
         reports_seen  = 0;
      endfunction

      function result_type make_report(logic [7:0] checksum);
         result_type rep;
         rep.frame_status = (~running_sum != checksum);
         rep.frame_length = length_held;
         rep.slot_size    = field_bytes[0];
         rep.dead_time    = field_bytes[1];
         rep.frame_size   = field_bytes[2];
         rep.frame_number = field_bytes[3];
         rep.indicator_on = ~previous_byte[0];
         return rep;
      endfunction

      // Advance the parse state by one accepted byte
      function void note_byte(logic [7:0] b);
         int idx;
         case (phase)
            PH_LENGTH: begin
               length_held = b;
               if (b == 8'd0) begin
                  reports_due.push_back(make_report(b));
                  phase    = PH_HUNT;
                  position = '0;
               end else begin
                  running_sum   = running_sum + b;
                  previous_byte = b;
                  position      = BODY_START;
                  phase         = PH_BODY;
               end
            end
            PH_BODY: begin
               if (position >= FIELD_FIRST && position <= FIELD_LAST) begin
                  idx = int'(position - FIELD_FIRST);
                  field_bytes[idx] = b;
               end
               if (position >= ({1'b0, length_held} + 9'd1)) begin
                  reports_due.push_back(make_report(b));
                  phase    = PH_HUNT;
                  position = '0;
               end else begin
                  running_sum   = running_sum + b;
                  previous_byte = b;
                  position      = position + 9'd1;
               end
            end
            default: begin
               // hunting, and the unused phase code
               if (b == START_MARKER) begin
                  running_sum   = b;
                  previous_byte = b;
                  position      = LENGTH_POS;
                  phase         = PH_LENGTH;
               end else begin
                  phase = PH_HUNT;
               end
            end
         endcase
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      // Compare one report transfer with the oldest expected report
      function void check_report(logic [RSP_WIDTH-1:0] data);
         result_type want;
         result_type got;
         reports_seen++;
         if (reports_due.size() == 0) begin
            $error("frame report with no frame pending: %h", data);
            errors++;
            return;
         end
         want = reports_due.pop_front();
         got  = result_type'(data[RESULT_BITS-1:0]);
         compare_field("frame_status", want.frame_status, got.frame_status);
         compare_field("frame_length", want.frame_length, got.frame_length);
         compare_field("slot_size",    want.slot_size,    got.slot_size);
         compare_field("dead_time",    want.dead_time,    got.dead_time);
         compare_field("frame_size",   want.frame_size,   got.frame_size);
         compare_field("frame_number", want.frame_number, got.frame_number);
         compare_field("indicator_on", want.indicator_on, got.indicator_on);
         compare_field("padding", 0, int'(data[RSP_WIDTH-1:RESULT_BITS]));
      endfunction

      function int pending();
         return reports_due.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = 8'd0;   // [7:0] rx_byte
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   // [0] frame_status, [8:1] frame_length, [16:9] slot_size,
   // [24:17] dead_time, [32:25] frame_size, [40:33] frame_number,
   // [41] indicator_on, upper bits zero
   logic [RSP_WIDTH-1:0] rsp_tdata;

   frame_scoreboard sb = new();
   int burst_left  = 0;
   int bytes_sent  = 0;
   int cycle_count = 0;
   int sink_mode   = 0;
   int sink_left   = 0;
   int sink_hold   = 0;

   sync_frame_receiver_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Check every report transfer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_report(rsp_tdata);
   end

   // Stall the report side: always ready, coin flips, or long holds
   always @(negedge clock) begin
      logic ready_next;
      if (sink_left == 0) begin
         sink_mode = $urandom_range(0, 2);
         sink_left = $urandom_range(20, 150);
      end
      sink_left--;
      case (sink_mode)
         0: ready_next = 1'b1;
         1: ready_next = 1'($urandom_range(0, 1));
         default: begin
            if (sink_hold > 0) begin
               sink_hold--;
               ready_next = 1'b0;
            end else begin
               ready_next = 1'b1;
               if ($urandom_range(0, 3) == 0) sink_hold = $urandom_range(1, 12);
            end
         end
      endcase
      rsp_tready <= ready_next;
   end

   // Present one byte, idling between bursts; called and returns at negedge
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 7) == 0) begin
            gap        = 0;
            burst_left = $urandom_range(60, 200);
         end else begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
         end
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(b);
      burst_left--;
      bytes_sent++;
      @(negedge clock);
   endtask

   function automatic logic [7:0] body_byte();
      return ($urandom_range(0, 15) == 0) ? START_MARKER : 8'($urandom_range(0, 255));
   endfunction

   // Send marker, length and, for len > 0, body and checksum; corrupt on request
   task automatic send_frame(input int len, input bit corrupt);
      logic [7:0] sum;
      logic [7:0] d;
      logic [7:0] csum;
      int i;
      sum = START_MARKER + 8'(len);
      send_byte(START_MARKER);
      send_byte(8'(len));
      if (len > 0) begin
         for (i = 2; i <= len; i++) begin
            d   = body_byte();
            sum = sum + d;
            send_byte(d);
         end
         csum = ~sum;
         if (corrupt) csum = csum ^ 8'($urandom_range(1, 255));
         send_byte(csum);
      end
   endtask

   task automatic send_noise(input int count);
      repeat (count) send_byte(8'($urandom_range(0, 254)));
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 12);
      if (r < 90) return $urandom_range(13, 40);
      if (r < 97) return $urandom_range(41, 120);
      return $urandom_range(250, 255);
   endfunction

   initial begin
      int kind;
      int len;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: ignored noise, zero length, good and bad short frames,
      // marker bytes inside a frame, checksum landing on a field position
      send_byte(8'h00);
      send_byte(8'h7F);
      send_byte(8'hFE);
      send_frame(0, 1'b0);
      send_frame(1, 1'b0);
      send_frame(1, 1'b1);
      send_byte(START_MARKER);
      send_byte(8'h02);
      send_byte(START_MARKER);
      send_byte(8'hFF);
      send_frame(6, 1'b0);

      // Random: mostly well-formed frames, some bad, noise and cut frames
      while (bytes_sent < BYTE_TARGET) begin
         kind = $urandom_range(0, 99);
         len  = pick_length();
         if (kind < 75) begin
            send_frame(len, 1'b0);
         end else if (kind < 85) begin
            send_frame((len == 0) ? 1 : len, 1'b1);
         end else if (kind < 93) begin
            send_noise($urandom_range(1, 6));
         end else begin
            // cut frame: the following bytes finish it
            send_byte(START_MARKER);
            send_byte(8'($urandom_range(1, 20)));
            repeat ($urandom_range(0, 4)) send_byte(body_byte());
         end
      end
      req_tvalid <= 1'b0;

      // Drain the reports, then let the pipeline settle
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
